/* hw/rtl/bmpu_pkg.sv */
// Shared types and constants for the bitmap pixel unpacker.
package bmpu_pkg;

    // Image size limits accepted from the header
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // Counter widths follow the limits; tags on the ports are fixed at 12 bits
    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int TAG_W = 12;

    localparam int HDR_W         = 6;
    localparam int HEADER_BYTES  = 54;
    localparam int OFS_WIDTH     = 18;
    localparam int OFS_HEIGHT    = 22;
    localparam int OFS_BPP       = 28;

    localparam logic [15:0] BPP_GRAY = 16'd8;
    localparam logic [15:0] BPP_RGB  = 16'd24;
    localparam logic [15:0] BPP_RGBA = 16'd32;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_IGNORE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_PIXEL  = 2'd0,
        ST_REJECT = 2'd1,
        ST_TRUNC  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]       pixel_byte;
        logic [TAG_W-1:0] column;
        logic [TAG_W-1:0] row;
        logic [1:0]       channel;
        status_t          status;
        logic             image_last;
    } result_t;

endpackage

/* hw/rtl/bmpu_step.sv */
// Header capture, pixel counters and per-word result decode.
module bmpu_step
    import bmpu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       file_last,
    output logic       res_valid,
    output result_t    res
);

    phase_t           phase_reg,    phase_next;
    logic [HDR_W-1:0] hdr_cnt_reg,  hdr_cnt_next;
    logic [31:0]      width_reg,    width_next;
    logic [31:0]      height_reg,   height_next;
    logic [15:0]      bpp_reg,      bpp_next;
    logic [2:0]       chan_num_reg, chan_num_next;
    logic [COL_W-1:0] col_reg,      col_next;
    logic [ROW_W-1:0] row_reg,      row_next;
    logic [1:0]       chan_reg,     chan_next;
    logic [1:0]       pad_reg,      pad_next;
    logic [1:0]       row_pad_reg,  row_pad_next;

    logic             hdr_end;
    logic [2:0]       chan_num_calc;
    logic             hdr_ok;
    logic [1:0]       pad_prod;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             chan_wrap;
    logic             col_wrap;
    logic             row_wrap;
    logic             done;
    logic             clear_file;
    logic [HDR_W-1:0] lane_w;
    logic [HDR_W-1:0] lane_h;

    assign hdr_end = (hdr_cnt_reg == HDR_W'(HEADER_BYTES - 1));

    always_comb begin
        case (bpp_reg)
            BPP_GRAY: chan_num_calc = 3'd1;
            BPP_RGB:  chan_num_calc = 3'd3;
            BPP_RGBA: chan_num_calc = 3'd4;
            default:  chan_num_calc = 3'd0;
        endcase
    end

    // bit 31 set means negative; the unsigned limit check already excludes it
    assign hdr_ok = (chan_num_calc != 3'd0)
                 && (width_reg != 32'd0)  && (width_reg <= 32'(MAX_WIDTH))
                 && (height_reg != 32'd0) && (height_reg <= 32'(MAX_HEIGHT));

    // bytes per row mod 4, then pad up to the next multiple of four
    assign pad_prod = 2'(width_reg[1:0] * chan_num_calc[1:0]);

    assign col_inc   = col_reg + COL_W'(1);
    assign row_inc   = row_reg + ROW_W'(1);
    assign chan_wrap = ({1'b0, chan_reg} + 3'd1) >= chan_num_reg;
    assign col_wrap  = 32'(col_inc) >= width_reg;
    assign row_wrap  = 32'(row_inc) >= height_reg;
    assign done      = chan_wrap && col_wrap && row_wrap;

    assign lane_w = hdr_cnt_reg - HDR_W'(OFS_WIDTH);
    assign lane_h = hdr_cnt_reg - HDR_W'(OFS_HEIGHT);

    // next state
    always_comb begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        bpp_next      = bpp_reg;
        chan_num_next = chan_num_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        chan_next     = chan_reg;
        pad_next      = pad_reg;
        row_pad_next  = row_pad_reg;
        clear_file    = 1'b0;
        if (fire) begin
            case (phase_reg)
                PH_HEADER: begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
                    if (lane_w < HDR_W'(4)) begin
                        width_next[8*lane_w[1:0] +: 8] = data_byte;
                    end else if (lane_h < HDR_W'(4)) begin
                        height_next[8*lane_h[1:0] +: 8] = data_byte;
                    end else if (hdr_cnt_reg == HDR_W'(OFS_BPP)) begin
                        bpp_next[7:0] = data_byte;
                    end else if (hdr_cnt_reg == HDR_W'(OFS_BPP + 1)) begin
                        bpp_next[15:8] = data_byte;
                    end
                    if (hdr_end) begin
                        if (file_last) begin
                            clear_file = 1'b1;
                        end else if (!hdr_ok) begin
                            phase_next = PH_IGNORE;
                        end else begin
                            chan_num_next = chan_num_calc;
                            row_pad_next  = 2'd0 - pad_prod;
                            phase_next    = PH_PIXELS;
                        end
                    end else if (file_last) begin
                        clear_file = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    if (pad_reg != 2'd0) begin
                        pad_next = pad_reg - 2'd1;
                    end else begin
                        chan_next = chan_reg + 2'd1;
                        if (chan_wrap) begin
                            chan_next = 2'd0;
                            col_next  = col_inc;
                            if (col_wrap) begin
                                col_next = '0;
                                row_next = row_inc;
                                if (row_wrap) begin
                                    phase_next = PH_IGNORE;
                                end else begin
                                    pad_next = row_pad_reg;
                                end
                            end
                        end
                    end
                    if (file_last) begin
                        clear_file = 1'b1;
                    end
                end
                default: begin
                    if (file_last) begin
                        clear_file = 1'b1;
                    end
                end
            endcase
        end
        if (clear_file) begin
            phase_next    = PH_HEADER;
            hdr_cnt_next  = '0;
            width_next    = '0;
            height_next   = '0;
            bpp_next      = '0;
            chan_num_next = '0;
            col_next      = '0;
            row_next      = '0;
            chan_next     = '0;
            pad_next      = '0;
            row_pad_next  = '0;
        end
    end

    // result decode
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        res.status = ST_PIXEL;
        if (fire) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (hdr_end) begin
                        res_valid      = !hdr_ok || file_last;
                        res.status     = hdr_ok ? ST_TRUNC : ST_REJECT;
                        res.image_last = 1'b1;
                    end else if (file_last) begin
                        res_valid      = 1'b1;
                        res.status     = ST_TRUNC;
                        res.image_last = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    if (pad_reg != 2'd0 || (file_last && !done)) begin
                        res_valid      = file_last;
                        res.status     = ST_TRUNC;
                        res.image_last = 1'b1;
                    end else begin
                        res_valid      = 1'b1;
                        res.pixel_byte = data_byte;
                        res.column     = TAG_W'(col_reg);
                        res.row        = TAG_W'(row_reg);
                        res.channel    = chan_reg;
                        res.image_last = done;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_reg      <= '0;
            chan_num_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            chan_reg     <= '0;
            pad_reg      <= '0;
            row_pad_reg  <= '0;
        end else begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            chan_num_reg <= chan_num_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            chan_reg     <= chan_next;
            pad_reg      <= pad_next;
            row_pad_reg  <= row_pad_next;
        end
    end

endmodule

/* hw/rtl/bmp_pixel_unpacker_core.sv */
// Top level: input word register, decode step and result register.
//
//  channel  dir  tdata                         tuser        tlast
//  s_       in   [7:0] data_byte               -            file_last
//  m_       out  [7:0] pixel_byte, [19:8] col, [1:0] status image_last
//                [31:20] row, [33:32] channel
//
// One file byte per cycle unless m_tready stalls the decode step; each byte passes
// through the input register and then the result register around the decode step.
// The 54 header bytes and row padding give no pixel word, only reject/trunc status.
// Synchronous active-low reset returns to header collection with empty registers.
// m_tready low while a result word is held stalls the decode step; one more byte is
// still taken into the input register if that register is empty.
module bmp_pixel_unpacker_core
    import bmpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel_byte, [19:8] column, [31:20] row,
                                   // [33:32] channel, [39:34] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic       fire;
    logic       s_fire;
    logic       res_valid;
    result_t    res;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    bmpu_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .file_last (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.channel, out_res_reg.row,
                       out_res_reg.column, out_res_reg.pixel_byte};
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.image_last;

    // status words carry no pixel tags and always close the image
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_PIXEL) |-> (m_tdata == 40'd0 && m_tlast))
        else $error("status word with pixel tags or without image_last");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_PIXEL || m_tuser == ST_REJECT || m_tuser == ST_TRUNC))
        else $error("undefined status code");

    // a held input word is never dropped without being decoded
    a_in_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("input word lost while stalled");

endmodule
